/* hw/rtl/hwtf_pkg.sv */
// shared types, constants and register codes for the homography temperature fetch
package hwtf_pkg;

  localparam int StoreDepthDef = 524288;
  localparam int AccW = 52;
  localparam int DivW = 28;
  localparam int IdxW = 25;
  localparam int CfgW = 64;
  localparam int CfgIdxW = 3;

  localparam logic [63:0] CoefARst = 64'h1000000001000000;
  localparam logic [63:0] CoefBRst = 64'h0;
  localparam logic [63:0] CoefCRst = 64'h0100000000000000;
  localparam logic [63:0] CoefDRst = 64'h0;
  localparam logic [31:0] OffsetRst = 32'h0;
  localparam logic [23:0] SizeRst = 24'h280200;
  localparam logic [7:0] BorderRst = 8'h0;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A = 3'd0,
    REG_COEF_B = 3'd1,
    REG_COEF_C = 3'd2,
    REG_COEF_D = 3'd3,
    REG_OFFSET = 3'd4,
    REG_SIZE = 3'd5,
    REG_BORDER = 3'd6,
    REG_PAIR = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] coef_a;
    logic [63:0] coef_b;
    logic [63:0] coef_c;
    logic [63:0] coef_d;
    logic [31:0] offset;
    logic [23:0] size;
    logic [7:0] border;
    logic pair;
  } cfg_t;

  typedef struct packed {
    op_t op;
    logic [18:0] sidx;
    logic [15:0] sval;
    logic signed [AccW-1:0] acc_x;
    logic signed [AccW-1:0] acc_y;
    logic signed [AccW-1:0] acc_w;
  } qent_t;

endpackage

/* hw/rtl/hwtf_if.sv */
// valid/ready channel interfaces for input and result words
interface hwtf_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [18:0] sample_index;
  logic signed [15:0] sample_value;
  logic [16:0] query_x;
  logic [16:0] query_y;
  modport source(output valid, op, sample_index, sample_value, query_x, query_y, input ready);
  modport sink(input valid, op, sample_index, sample_value, query_x, query_y, output ready);
endinterface

interface hwtf_out_if;
  logic valid;
  logic ready;
  logic is_valid;
  logic signed [15:0] temperature;
  modport source(output valid, is_valid, temperature, input ready);
  modport sink(input valid, is_valid, temperature, output ready);
endinterface

/* hw/rtl/homography_warp_temperature_fetch_core.sv */
// top level: configuration registers, front end, queue and back end
// A write word passes the front end into the queue; the back end writes it to the store as
// it pops it. A query word takes six products through one shared multiplier in the front
// end, is popped from the queue, and in the back end runs the bit-serial perspective divider
// on both coordinates together, then offset, border test and store read. A query found
// invalid before the divide skips it. The back end pops no new query until its result is
// out, which sets the rate of a query stream; the two-entry queue lets the front end take
// and prepare the next word while the back end divides or a result waits.
// Store entries never written read back undefined; no clearing pass runs after reset.
module homography_warp_temperature_fetch_core import hwtf_pkg::*; #(
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  hwtf_in_if.sink in_ch,
  hwtf_out_if.source out_ch
);

  cfg_t cfg_r;
  logic push, pop, empty, full;
  qent_t push_ent, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_a <= CoefARst;
      cfg_r.coef_b <= CoefBRst;
      cfg_r.coef_c <= CoefCRst;
      cfg_r.coef_d <= CoefDRst;
      cfg_r.offset <= OffsetRst;
      cfg_r.size <= SizeRst;
      cfg_r.border <= BorderRst;
      cfg_r.pair <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_A: cfg_r.coef_a <= cfg_wdata;
        REG_COEF_B: cfg_r.coef_b <= cfg_wdata;
        REG_COEF_C: cfg_r.coef_c <= cfg_wdata;
        REG_COEF_D: cfg_r.coef_d <= cfg_wdata;
        REG_OFFSET: cfg_r.offset <= cfg_wdata[31:0];
        REG_SIZE: cfg_r.size <= cfg_wdata[23:0];
        REG_BORDER: cfg_r.border <= cfg_wdata[7:0];
        REG_PAIR: cfg_r.pair <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  hwtf_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_ch(in_ch),
    .push(push), .push_ent(push_ent), .full(full)
  );

  hwtf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_ent(push_ent),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  hwtf_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .empty(empty),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

/* hw/rtl/hwtf_front.sv */
// front end: accepts words and forms the projective sums with one shared multiplier
module hwtf_front import hwtf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  hwtf_in_if.sink in_ch,
  output logic push,
  output qent_t push_ent,
  input  logic full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fst_t;

  fst_t st_r, st_nxt;
  qent_t ent_r;
  logic [2:0] step_r;
  logic pv_r;
  logic [1:0] ptgt_r;
  logic signed [49:0] prod_r;
  logic [16:0] qx_r, qy_r;
  logic [31:0] coef;
  logic [16:0] opnd;
  logic signed [AccW-1:0] padd;

  assign in_ch.ready = (st_r == F_IDLE);
  assign push = (st_r == F_PUSH) && !full;
  assign push_ent = ent_r;

  always_comb begin
    case (step_r)
      3'd0: coef = cfg.coef_a[63:32];
      3'd1: coef = cfg.coef_a[31:0];
      3'd2: coef = cfg.coef_b[31:0];
      3'd3: coef = cfg.coef_c[63:32];
      3'd4: coef = cfg.coef_d[63:32];
      3'd5: coef = cfg.coef_d[31:0];
      default: coef = 32'h0;
    endcase
    opnd = step_r[0] ? qy_r : qx_r;
    padd = AccW'(prod_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: begin
        if (in_ch.valid) st_nxt = (in_ch.op == OP_QUERY) ? F_MUL : F_PUSH;
      end
      F_MUL: begin
        if (step_r == 3'd6) st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      pv_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_IDLE && in_ch.valid) begin
        step_r <= 3'd0;
        pv_r <= 1'b0;
      end else if (st_r == F_MUL) begin
        pv_r <= (step_r != 3'd6);
        if (step_r != 3'd6) step_r <= step_r + 3'd1;
      end else begin
        pv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_ch.valid) begin
      ent_r.op <= op_t'(in_ch.op);
      ent_r.sidx <= in_ch.sample_index;
      ent_r.sval <= in_ch.sample_value;
      ent_r.acc_x <= {{8{cfg.coef_b[63]}}, cfg.coef_b[63:32], 12'b0};
      ent_r.acc_y <= {{8{cfg.coef_c[31]}}, cfg.coef_c[31:0], 12'b0};
      ent_r.acc_w <= AccW'(1) <<< 44;
      qx_r <= in_ch.query_x;
      qy_r <= in_ch.query_y;
    end else if (st_r == F_MUL) begin
      if (step_r != 3'd6) begin
        prod_r <= $signed(coef) * $signed({1'b0, opnd});
        ptgt_r <= step_r[2:1];
      end
      if (pv_r) begin
        case (ptgt_r)
          2'd0: ent_r.acc_x <= ent_r.acc_x + padd;
          2'd1: ent_r.acc_y <= ent_r.acc_y + padd;
          default: ent_r.acc_w <= ent_r.acc_w + padd;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/hwtf_queue.sv */
// two-entry queue between front and back
module hwtf_queue import hwtf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  qent_t push_ent,
  input  logic pop,
  output qent_t head,
  output logic empty,
  output logic full
);

  qent_t slot_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full = (cnt_r == 2'd2);
  assign head = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_ent;
  end

endmodule

/* hw/rtl/hwtf_back.sv */
// back end: sample store, perspective divide, border test and fetch
module hwtf_back import hwtf_pkg::*; #(
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  qent_t head,
  input  logic empty,
  output logic pop,
  hwtf_out_if.source out_ch
);

  localparam int AddrW = $clog2(STORE_DEPTH);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_DIV  = 7'b0000010,
    B_OFS  = 7'b0000100,
    B_RECT = 7'b0001000,
    B_ADDR = 7'b0010000,
    B_RD   = 7'b0100000,
    B_OUT  = 7'b1000000
  } bst_t;

  bst_t st_r;
  logic loaded_r;
  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rd_r;
  logic [AddrW-1:0] addr;
  logic we;

  logic [AccW-1:0] num_x_r, num_y_r, quo_x_r, quo_y_r;
  logic [DivW:0] rem_x_r, rem_y_r;
  logic [DivW-1:0] div_r;
  logic neg_x_r, neg_y_r;
  logic [5:0] cnt_r;
  logic signed [AccW+1:0] px_r, py_r;
  logic [IdxW-1:0] idx_r;
  logic res_v_r;
  logic [15:0] res_t_r;
  logic out_v_r, out_iv_r;
  logic [15:0] out_t_r;

  logic [DivW:0] sh_x, sh_y;
  logic gx, gy;
  logic [AccW-1:0] mag_x, mag_y;
  logic signed [AccW:0] sq_x, sq_y;
  logic [DivW-1:0] w20;
  logic wr_ok, persp_ok;
  logic [IdxW-1:0] widx;
  logic signed [12:0] wb, hb;
  logic signed [AccW+1:0] bq, wq, hq;
  logic in_rect;

  assign pop = (st_r == B_IDLE) && !empty;
  assign widx = IdxW'(head.sidx);
  assign wr_ok = 32'(widx) < 32'(STORE_DEPTH);
  assign we = pop && (head.op == OP_WRITE) && wr_ok;
  assign addr = (st_r == B_IDLE) ? widx[AddrW-1:0] : idx_r[AddrW-1:0];
  assign w20 = head.acc_w[AccW-1:24];
  assign persp_ok = !head.acc_w[AccW-1] && (w20 != '0);
  assign mag_x = head.acc_x[AccW-1] ? AccW'(-head.acc_x) : head.acc_x;
  assign mag_y = head.acc_y[AccW-1] ? AccW'(-head.acc_y) : head.acc_y;

  assign sh_x = {rem_x_r[DivW-1:0], num_x_r[AccW-1]};
  assign sh_y = {rem_y_r[DivW-1:0], num_y_r[AccW-1]};
  assign gx = sh_x >= {1'b0, div_r};
  assign gy = sh_y >= {1'b0, div_r};
  assign sq_x = neg_x_r ? -$signed({1'b0, quo_x_r}) : $signed({1'b0, quo_x_r});
  assign sq_y = neg_y_r ? -$signed({1'b0, quo_y_r}) : $signed({1'b0, quo_y_r});

  assign wb = $signed({1'b0, cfg.size[23:12]}) - $signed({5'b0, cfg.border});
  assign hb = $signed({1'b0, cfg.size[11:0]}) - $signed({5'b0, cfg.border});
  assign bq = {38'b0, cfg.border, 8'b0};
  assign wq = {{33{wb[12]}}, wb, 8'b0};
  assign hq = {{33{hb[12]}}, hb, 8'b0};
  assign in_rect = (px_r >= bq) && (px_r <= wq) && (py_r >= bq) && (py_r <= hq);

  assign out_ch.valid = out_v_r;
  assign out_ch.is_valid = out_iv_r;
  assign out_ch.temperature = out_t_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= head.sval;
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      loaded_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (we) loaded_r <= 1'b1;
      if (st_r == B_OUT && (!out_v_r || out_ch.ready)) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      case (st_r)
        B_IDLE: begin
          if (pop && head.op == OP_QUERY) begin
            if (!cfg.pair || !loaded_r || !persp_ok) st_r <= B_OUT;
            else st_r <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt_r == 6'(AccW - 1)) st_r <= B_OFS;
        end
        B_OFS: st_r <= B_RECT;
        B_RECT: st_r <= in_rect ? B_ADDR : B_OUT;
        B_ADDR: st_r <= (32'(idx_r) >= 32'(STORE_DEPTH)) ? B_OUT : B_RD;
        B_RD: st_r <= B_OUT;
        B_OUT: begin
          if (!out_v_r || out_ch.ready) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        res_v_r <= 1'b0;
        res_t_r <= 16'h0;
        num_x_r <= mag_x;
        num_y_r <= mag_y;
        neg_x_r <= head.acc_x[AccW-1];
        neg_y_r <= head.acc_y[AccW-1];
        div_r <= w20;
        rem_x_r <= '0;
        rem_y_r <= '0;
        cnt_r <= 6'd0;
      end
      B_DIV: begin
        rem_x_r <= gx ? sh_x - {1'b0, div_r} : sh_x;
        rem_y_r <= gy ? sh_y - {1'b0, div_r} : sh_y;
        quo_x_r <= {quo_x_r[AccW-2:0], gx};
        quo_y_r <= {quo_y_r[AccW-2:0], gy};
        num_x_r <= num_x_r << 1;
        num_y_r <= num_y_r << 1;
        cnt_r <= cnt_r + 6'd1;
      end
      B_OFS: begin
        px_r <= (AccW+2)'(sq_x) + (AccW+2)'($signed(cfg.offset[31:16]));
        py_r <= (AccW+2)'(sq_y) + (AccW+2)'($signed(cfg.offset[15:0]));
      end
      B_RECT: begin
        idx_r <= IdxW'(py_r[19:8] * cfg.size[23:12]) + IdxW'(px_r[19:8]);
      end
      B_RD: begin
        res_v_r <= 1'b1;
        res_t_r <= rd_r;
      end
      B_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          out_iv_r <= res_v_r;
          out_t_r <= res_t_r;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_iv_r) |-> (out_t_r == 16'h0))
    else $error("invalid result carries a sample");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV) |-> (div_r != '0))
    else $error("divide by zero perspective");
  a_addr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_ADDR) |-> (!px_r[AccW+1] && !py_r[AccW+1]))
    else $error("negative point reached the store");
`endif

endmodule
